### sv/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and codes for the WebSocket frame deframer: parse phases,
// result kinds, opcodes and header length codes.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int ByteW   = 8;
	localparam int KindW   = 2;
	localparam int OpcodeW = 4;
	localparam int CountW  = 64;
	localparam int KeyW    = 32;
	localparam int ExtW    = 4;
	localparam int KeyCntW = 3;
	localparam int IdxW    = 2;
	localparam int Len7W   = 7;

	// Parse phase of the receive side.
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT     = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	typedef logic [KindW-1:0]   kind_t;
	typedef logic [OpcodeW-1:0] opcode_t;

	localparam kind_t KIND_DATA  = 2'd0;
	localparam kind_t KIND_PING  = 2'd1;
	localparam kind_t KIND_CLOSE = 2'd2;
	localparam kind_t KIND_EMPTY = 2'd3;

	localparam opcode_t OP_CLOSE = 4'h8;
	localparam opcode_t OP_PING  = 4'h9;

	localparam logic [Len7W-1:0] LEN_EXT16 = 7'd126;
	localparam logic [Len7W-1:0] LEN_EXT64 = 7'd127;

	localparam logic [ExtW-1:0]    EXT16_BYTES = 4'd2;
	localparam logic [ExtW-1:0]    EXT64_BYTES = 4'd8;
	localparam logic [KeyCntW-1:0] KEY_BYTES   = 3'd4;

endpackage

### sv/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: takes one stream byte per request,
// tracks header, extended length and masking key, and emits unmasked payload
// bytes and close / empty-message events.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  input   | in        | in_valid / in_stall  | in_byte, restart
//  output  | out       | out_valid / out_stall| out_byte, result_kind,
//          |           |                      | frame_opcode, frame_fin,
//          |           |                      | last_of_frame
//
// One input request is accepted every cycle while the input is not stalled. Each
// accepted byte is handled in the cycle it is accepted: the parse state registers
// update at that edge and any result is loaded into the output register, so a
// result appears in the cycle after its byte. The input stalls only while the
// output register holds a result that the downstream side is stalling; when the
// held result is taken in the same cycle, a new byte is accepted alongside. The
// asynchronous reset (arst_n low) returns the parser to expecting a first header
// byte and empties the output register.
//
module websocket_frame_deframer (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [wsfd_pkg::ByteW-1:0]   in_byte,
	input  logic                         restart,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wsfd_pkg::ByteW-1:0]   out_byte,
	output wsfd_pkg::kind_t              result_kind,
	output wsfd_pkg::opcode_t            frame_opcode,
	output logic                         frame_fin,
	output logic                         last_of_frame
);

	// Parse state.
	wsfd_pkg::phase_t                    phase_q, phase_d;
	logic [wsfd_pkg::ExtW-1:0]           ext_left_q, ext_left_d;
	logic [wsfd_pkg::CountW-1:0]         remaining_q, remaining_d;
	logic [wsfd_pkg::KeyW-1:0]           mask_key_q, mask_key_d;
	logic                                mask_present_q, mask_present_d;
	logic [wsfd_pkg::KeyCntW-1:0]        key_left_q, key_left_d;
	logic [wsfd_pkg::IdxW-1:0]           pay_idx_q, pay_idx_d;
	wsfd_pkg::opcode_t                   opcode_q, opcode_d;
	logic                                fin_q, fin_d;

	// Output register.
	logic                                out_valid_q;
	logic [wsfd_pkg::ByteW-1:0]          out_byte_q;
	wsfd_pkg::kind_t                     out_kind_q;
	wsfd_pkg::opcode_t                   out_opcode_q;
	logic                                out_fin_q;
	logic                                out_last_q;

	// Combinational step results.
	wsfd_pkg::phase_t                    cur_phase;
	logic                                fire;
	logic                                hdr_done;
	logic [wsfd_pkg::CountW-1:0]         length_val;
	logic [wsfd_pkg::CountW-1:0]         rem_dec;
	logic [wsfd_pkg::KeyCntW-1:0]        key_left_dec;
	logic [wsfd_pkg::ExtW-1:0]           ext_left_dec;
	logic [wsfd_pkg::Len7W-1:0]          len7;
	logic [wsfd_pkg::ByteW-1:0]          key_byte;

	logic                                res_valid;
	logic [wsfd_pkg::ByteW-1:0]          res_byte;
	wsfd_pkg::kind_t                     res_kind;
	logic                                res_last;

	// A byte may enter unless a held result is being stalled downstream.
	assign in_stall = out_valid_q & out_stall;
	assign fire     = in_valid & ~in_stall;

	// A restart byte is always parsed as a first header byte.
	assign cur_phase = restart ? wsfd_pkg::PH_HDR0 : phase_q;

	assign len7         = in_byte[wsfd_pkg::Len7W-1:0];
	assign rem_dec      = remaining_q - {{(wsfd_pkg::CountW-1){1'b0}}, 1'b1};
	assign key_left_dec = key_left_q - {{(wsfd_pkg::KeyCntW-1){1'b0}}, 1'b1};
	assign ext_left_dec = ext_left_q - {{(wsfd_pkg::ExtW-1){1'b0}}, 1'b1};

	// The first key byte sits in the top of the key word.
	always_comb begin
		case (pay_idx_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	// Next-state logic. When the header completes (length and key known), the
	// frame either raises an event, skipping any close payload, or moves into its payload.
	always_comb begin
		phase_d        = phase_q;
		ext_left_d     = ext_left_q;
		remaining_d    = remaining_q;
		mask_key_d     = mask_key_q;
		mask_present_d = mask_present_q;
		key_left_d     = key_left_q;
		pay_idx_d      = pay_idx_q;
		opcode_d       = opcode_q;
		fin_d          = fin_q;
		hdr_done       = 1'b0;
		length_val     = remaining_q;

		unique case (cur_phase)
			wsfd_pkg::PH_HDR0: begin
				fin_d          = in_byte[7];
				opcode_d       = in_byte[wsfd_pkg::OpcodeW-1:0];
				mask_present_d = 1'b0;
				mask_key_d     = '0;
				remaining_d    = '0;
				ext_left_d     = '0;
				key_left_d     = '0;
				pay_idx_d      = '0;
				phase_d        = wsfd_pkg::PH_HDR1;
			end
			wsfd_pkg::PH_HDR1: begin
				mask_present_d = in_byte[7];
				if (len7 == wsfd_pkg::LEN_EXT16) begin
					remaining_d = '0;
					ext_left_d  = wsfd_pkg::EXT16_BYTES;
					phase_d     = wsfd_pkg::PH_EXT;
				end else if (len7 == wsfd_pkg::LEN_EXT64) begin
					remaining_d = '0;
					ext_left_d  = wsfd_pkg::EXT64_BYTES;
					phase_d     = wsfd_pkg::PH_EXT;
				end else begin
					length_val  = {{(wsfd_pkg::CountW-wsfd_pkg::Len7W){1'b0}}, len7};
					remaining_d = length_val;
					if (in_byte[7]) begin
						key_left_d = wsfd_pkg::KEY_BYTES;
						mask_key_d = '0;
						phase_d    = wsfd_pkg::PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_EXT: begin
				length_val  = {remaining_q[wsfd_pkg::CountW-wsfd_pkg::ByteW-1:0], in_byte};
				remaining_d = length_val;
				ext_left_d  = ext_left_dec;
				if (ext_left_dec == '0) begin
					if (mask_present_q) begin
						key_left_d = wsfd_pkg::KEY_BYTES;
						mask_key_d = '0;
						phase_d    = wsfd_pkg::PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			wsfd_pkg::PH_KEY: begin
				mask_key_d = {mask_key_q[wsfd_pkg::KeyW-wsfd_pkg::ByteW-1:0], in_byte};
				key_left_d = key_left_dec;
				if (key_left_dec == '0) begin
					hdr_done = 1'b1;
				end
			end
			wsfd_pkg::PH_PAYLOAD: begin
				pay_idx_d   = pay_idx_q + {{(wsfd_pkg::IdxW-1){1'b0}}, 1'b1};
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = wsfd_pkg::PH_HDR0;
				end
			end
			wsfd_pkg::PH_SKIP: begin
				remaining_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = wsfd_pkg::PH_HDR0;
				end
			end
			default: begin
				phase_d = wsfd_pkg::PH_HDR0;
			end
		endcase

		if (hdr_done) begin
			pay_idx_d = '0;
			if (opcode_q == wsfd_pkg::OP_CLOSE) begin
				phase_d = (length_val != '0) ? wsfd_pkg::PH_SKIP : wsfd_pkg::PH_HDR0;
			end else if (length_val == '0) begin
				phase_d = wsfd_pkg::PH_HDR0;
			end else begin
				phase_d = wsfd_pkg::PH_PAYLOAD;
			end
		end
	end

	// Result logic: payload bytes, or a single event when the header completes
	// for a close frame or for an empty frame.
	always_comb begin
		res_valid = 1'b0;
		res_byte  = '0;
		res_kind  = wsfd_pkg::KIND_DATA;
		res_last  = 1'b0;

		unique case (cur_phase)
			wsfd_pkg::PH_PAYLOAD: begin
				res_valid = 1'b1;
				res_byte  = mask_present_q ? (in_byte ^ key_byte) : in_byte;
				res_kind  = (opcode_q == wsfd_pkg::OP_PING) ? wsfd_pkg::KIND_PING
				                                            : wsfd_pkg::KIND_DATA;
				res_last  = (rem_dec == '0);
			end
			default: begin
				if (hdr_done) begin
					if (opcode_q == wsfd_pkg::OP_CLOSE) begin
						res_valid = 1'b1;
						res_kind  = wsfd_pkg::KIND_CLOSE;
						res_last  = 1'b1;
					end else if (length_val == '0) begin
						res_valid = 1'b1;
						res_kind  = wsfd_pkg::KIND_EMPTY;
						res_last  = 1'b1;
					end
				end
			end
		endcase
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= wsfd_pkg::PH_HDR0;
			ext_left_q     <= '0;
			remaining_q    <= '0;
			mask_key_q     <= '0;
			mask_present_q <= 1'b0;
			key_left_q     <= '0;
			pay_idx_q      <= '0;
			opcode_q       <= '0;
			fin_q          <= 1'b0;
		end else if (fire) begin
			phase_q        <= phase_d;
			ext_left_q     <= ext_left_d;
			remaining_q    <= remaining_d;
			mask_key_q     <= mask_key_d;
			mask_present_q <= mask_present_d;
			key_left_q     <= key_left_d;
			pay_idx_q      <= pay_idx_d;
			opcode_q       <= opcode_d;
			fin_q          <= fin_d;
		end
	end

	// Output register valid: loaded on an accepted byte, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload. The opcode and FIN shown are those of the frame in hand.
	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_byte_q   <= res_byte;
			out_kind_q   <= res_kind;
			out_opcode_q <= opcode_q;
			out_fin_q    <= fin_q;
			out_last_q   <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign result_kind   = out_kind_q;
	assign frame_opcode  = out_opcode_q;
	assign frame_fin     = out_fin_q;
	assign last_of_frame = out_last_q;

endmodule
